// ===== src/cedq_pkg.sv =====
`default_nettype none

package cedq_pkg;

	// One deque entry; x sits in the lowest bits so the packed form matches the stream layout
	typedef struct packed {
		logic [7:0]  side;
		logic [63:0] t;
		logic [63:0] y;
		logic [63:0] x;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_ROTATE     = 3'd3,
		OP_PEEK       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EMIT = 2'b10
	} state_t;

	localparam int unsigned OUT_DATA_W = 408;

endpackage

`default_nettype wire

// ===== src/circular_edge_deque_with_rotate.sv =====
// Bounded double-ended queue of edge entries (x, y, t, side) held in a ring of CAPACITY
// slots in one single-port-write, single-port-read synchronous memory. The front and back
// entries are also kept in registers, so push and peek need no memory read. A request is
// accepted and the memory written in the idle state; in the emit state the result is
// loaded into the output register, with the new back entry for pop and rotate coming
// from the memory read issued on acceptance. A new request is taken in the cycle after
// the result is loaded, so the block takes no new request while a result is pending;
// a stalled result holds the block in its emit state.
// The memory needs no clearing after reset: only occupied slots are ever read.
`default_nettype none

module circular_edge_deque_with_rotate #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// point_x [63:0], point_y [127:64], param_t [191:128], side_number [199:192]
	input  wire logic [199:0] s_tdata,
	// func [2:0]
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// entry_count [6:0], front_x [70:7], front_y [134:71], front_t [198:135],
	// front_side [206:199], back_x [270:207], back_y [334:271], back_t [398:335],
	// back_side [406:399], zero pad [407]
	output logic [407:0]      m_tdata,
	// status [1:0]
	output logic [1:0]        m_tuser
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = CW + 1;

	cedq_pkg::state_t  state_q;
	logic [AW-1:0]     fidx_q;
	logic [CW-1:0]     occ_q;
	cedq_pkg::entry_t  front_q;
	cedq_pkg::entry_t  back_q;
	cedq_pkg::status_t status_q;
	logic              use_rd_q;
	logic              m_tvalid_q;
	logic [407:0]      m_tdata_q;
	logic [1:0]        m_tuser_q;

	cedq_pkg::op_t     op;
	cedq_pkg::entry_t  in_entry;
	logic              accept;
	logic              emit;
	logic              full;
	logic [AW-1:0]     fidx_dec;
	logic [SW-1:0]     tail_sum;
	logic [AW-1:0]     tail_slot;
	logic [SW-1:0]     pen_sum;
	logic [AW-1:0]     pen_slot;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	cedq_pkg::entry_t  mem_wdata;
	logic              mem_re;
	cedq_pkg::entry_t  mem_rdata;

	cedq_pkg::status_t nx_status;
	logic [AW-1:0]     nx_fidx;
	logic [CW-1:0]     nx_occ;
	cedq_pkg::entry_t  nx_front;
	cedq_pkg::entry_t  nx_back;
	logic              nx_use_rd;

	cedq_pkg::entry_t  res_back;
	logic [CW+6:0]     cnt_ext;

	assign s_tready = (state_q == cedq_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign emit     = (state_q == cedq_pkg::S_EMIT) && (!m_tvalid_q || m_tready);
	assign op       = cedq_pkg::op_t'(s_tuser);
	assign in_entry = cedq_pkg::entry_t'(s_tdata);
	assign full     = (occ_q == CW'(CAPACITY));

	// Ring arithmetic: one compare and subtract suffices as every sum the memory uses stays below 2*CAPACITY
	assign fidx_dec  = (fidx_q == '0) ? AW'(CAPACITY - 1) : fidx_q - AW'(1);
	assign tail_sum  = SW'(fidx_q) + SW'(occ_q);
	assign tail_slot = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
	                                               : AW'(tail_sum);
	assign pen_sum   = SW'(fidx_q) + SW'(occ_q) - SW'(2);
	assign pen_slot  = (pen_sum >= SW'(CAPACITY)) ? AW'(pen_sum - SW'(CAPACITY))
	                                              : AW'(pen_sum);

	always_comb begin
		nx_status = cedq_pkg::ST_DONE;
		nx_fidx   = fidx_q;
		nx_occ    = occ_q;
		nx_front  = front_q;
		nx_back   = back_q;
		nx_use_rd = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = tail_slot;
		mem_wdata = in_entry;
		mem_re    = 1'b0;
		if (accept) begin
			unique case (op)
				cedq_pkg::OP_PUSH_BACK: begin
					if (full) begin
						nx_status = cedq_pkg::ST_FULL;
					end else begin
						mem_we  = 1'b1;
						nx_back = in_entry;
						if (occ_q == '0) begin
							nx_front = in_entry;
						end
						nx_occ = occ_q + CW'(1);
					end
				end
				cedq_pkg::OP_PUSH_FRONT: begin
					if (full) begin
						nx_status = cedq_pkg::ST_FULL;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = fidx_dec;
						nx_fidx   = fidx_dec;
						nx_front  = in_entry;
						if (occ_q == '0) begin
							nx_back = in_entry;
						end
						nx_occ = occ_q + CW'(1);
					end
				end
				cedq_pkg::OP_POP_BACK: begin
					if (occ_q == '0) begin
						nx_status = cedq_pkg::ST_NONE;
					end else begin
						nx_occ = occ_q - CW'(1);
						// fetch the entry that becomes the back
						if (occ_q >= CW'(2)) begin
							mem_re    = 1'b1;
							nx_use_rd = 1'b1;
						end
					end
				end
				cedq_pkg::OP_ROTATE: begin
					if (occ_q <= CW'(1)) begin
						nx_status = cedq_pkg::ST_NONE;
					end else begin
						// old back goes in the slot before the front, from its register
						mem_we    = 1'b1;
						mem_waddr = fidx_dec;
						mem_wdata = back_q;
						nx_fidx   = fidx_dec;
						nx_front  = back_q;
						mem_re    = 1'b1;
						nx_use_rd = 1'b1;
					end
				end
				cedq_pkg::OP_PEEK: begin
					nx_status = cedq_pkg::ST_DONE;
				end
				default: begin
					nx_status = cedq_pkg::ST_NONE;
				end
			endcase
		end
	end

	cedq_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (pen_slot),
		.rdata (mem_rdata)
	);

	assign res_back = use_rd_q ? mem_rdata : back_q;
	assign cnt_ext  = (CW + 7)'(occ_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cedq_pkg::S_IDLE;
			fidx_q     <= '0;
			occ_q      <= '0;
			use_rd_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q  <= cedq_pkg::S_EMIT;
				fidx_q   <= nx_fidx;
				occ_q    <= nx_occ;
				use_rd_q <= nx_use_rd;
			end else if (emit) begin
				state_q <= cedq_pkg::S_IDLE;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q  <= nx_front;
			back_q   <= nx_back;
			status_q <= nx_status;
		end else if (emit) begin
			back_q <= res_back;
		end
		if (emit) begin
			m_tuser_q <= status_q;
			if (occ_q == '0) begin
				m_tdata_q <= {401'd0, cnt_ext[6:0]};
			end else begin
				m_tdata_q <= {1'b0, res_back, front_q, cnt_ext[6:0]};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	ap_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("occupancy beyond capacity");

	ap_fidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fidx_q < AW'(CAPACITY - 1) || fidx_q == AW'(CAPACITY - 1))
		else $error("front index outside the ring");

	ap_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != pen_slot))
		else $error("rotate writes the slot it reads");

	ap_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!s_tready && state_q == cedq_pkg::S_EMIT))
		else $error("request not followed by its result cycle");

	ap_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && status_q == cedq_pkg::ST_FULL) |-> full)
		else $error("push rejected while not full");

endmodule

`default_nettype wire

// ===== src/cedq_mem.sv =====
`default_nettype none

module cedq_mem #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire cedq_pkg::entry_t      wdata,
	input  wire logic                  re,
	input  wire logic [AW-1:0]         raddr,
	output cedq_pkg::entry_t           rdata
);

	cedq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP        = 64;
	localparam int unsigned PERIOD     = 10;
	localparam int unsigned CYCLE_MAX  = 200000;
	localparam int unsigned LONG_HOLD  = 200;
	localparam int unsigned TAIL_WAIT  = 10;
	localparam logic [2:0]  FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  FUNC_SPARE_MID   = 3'd6;
	localparam logic [2:0]  FUNC_SPARE_LAST  = 3'd7;

	typedef struct {
		cedq_pkg::status_t status;
		logic [6:0]        count;
		cedq_pkg::entry_t  front;
		cedq_pkg::entry_t  back;
	} deque_view_t;

	class edge_deque_tracker;
		cedq_pkg::entry_t slot_mem [CAP];
		int unsigned      head = 0;
		int unsigned      fill = 0;
		int unsigned      errors = 0;
		deque_view_t      results_due [$];

		// apply one accepted request to the shadow ring and queue the view it yields
		function void log_request(logic [2:0] func, cedq_pkg::entry_t item);
			cedq_pkg::status_t st;
			cedq_pkg::entry_t  moved;
			deque_view_t       v;
			st = cedq_pkg::ST_DONE;
			case (func)
				cedq_pkg::OP_PUSH_BACK: begin
					if (fill == CAP) st = cedq_pkg::ST_FULL;
					else begin
						slot_mem[(head + fill) % CAP] = item;
						fill++;
					end
				end
				cedq_pkg::OP_PUSH_FRONT: begin
					if (fill == CAP) st = cedq_pkg::ST_FULL;
					else begin
						head = (head + CAP - 1) % CAP;
						slot_mem[head] = item;
						fill++;
					end
				end
				cedq_pkg::OP_POP_BACK: begin
					if (fill == 0) st = cedq_pkg::ST_NONE;
					else fill--;
				end
				cedq_pkg::OP_ROTATE: begin
					if (fill <= 1) st = cedq_pkg::ST_NONE;
					else begin
						moved = slot_mem[(head + fill - 1) % CAP];
						head = (head + CAP - 1) % CAP;
						slot_mem[head] = moved;
					end
				end
				cedq_pkg::OP_PEEK: ;
				default: st = cedq_pkg::ST_NONE;
			endcase
			v.status = st;
			v.count  = fill[6:0];
			v.front  = '0;
			v.back   = '0;
			if (fill != 0) begin
				v.front = slot_mem[head];
				v.back  = slot_mem[(head + fill - 1) % CAP];
			end
			results_due.push_back(v);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %h, got %h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] status, logic [407:0] data);
			deque_view_t      v;
			cedq_pkg::entry_t fr;
			cedq_pkg::entry_t bk;
			if (results_due.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			v  = results_due.pop_front();
			fr = cedq_pkg::entry_t'(data[206:7]);
			bk = cedq_pkg::entry_t'(data[406:207]);
			compare("status", v.status, status);
			compare("entry_count", v.count, data[6:0]);
			compare("front_x", v.front.x, fr.x);
			compare("front_y", v.front.y, fr.y);
			compare("front_t", v.front.t, fr.t);
			compare("front_side", v.front.side, fr.side);
			compare("back_x", v.back.x, bk.x);
			compare("back_y", v.back.y, bk.y);
			compare("back_t", v.back.t, bk.t);
			compare("back_side", v.back.side, bk.side);
			compare("pad", 64'd0, data[407]);
		endfunction

		function int unsigned pending();
			return results_due.size();
		endfunction
	endclass

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [199:0] s_tdata  = '0;
	logic [2:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [407:0] m_tdata;
	logic [1:0]   m_tuser;

	edge_deque_tracker tracker;
	int unsigned       cycle_count = 0;

	circular_edge_deque_with_rotate #(
		.CAPACITY(CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) tracker.log_request(s_tuser, cedq_pkg::entry_t'(s_tdata));
			if (m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata);
		end
	end

	initial begin
		while (cycle_count < CYCLE_MAX) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL circular_edge_deque_with_rotate");
		$finish;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic cedq_pkg::entry_t rand_entry();
		cedq_pkg::entry_t e;
		e.x    = {$urandom, $urandom};
		e.y    = {$urandom, $urandom};
		e.t    = {$urandom, $urandom};
		e.side = 8'($urandom_range(0, 255));
		return e;
	endfunction

	function automatic cedq_pkg::entry_t fixed_entry(logic [63:0] word, logic [7:0] side);
		cedq_pkg::entry_t e;
		e.x    = word;
		e.y    = ~word;
		e.t    = word ^ 64'h0123_4567_89ab_cdef;
		e.side = side;
		return e;
	endfunction

	// offer one request and hold it until taken, then optionally go quiet
	task automatic send(input logic [2:0] func, input cedq_pkg::entry_t item,
			input int unsigned gap);
		s_tuser  <= func;
		s_tdata  <= item;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned w_pb,
			input int unsigned w_pf, input int unsigned w_pop, input int unsigned w_rot,
			input int unsigned w_peek, input int unsigned w_spare);
		int unsigned total;
		int unsigned r;
		int unsigned gap;
		bit          steady;
		logic [2:0]  func;
		total  = w_pb + w_pf + w_pop + w_rot + w_peek + w_spare;
		steady = 1'b0;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 30 == 0) steady = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, total - 1);
			if (r < w_pb) func = cedq_pkg::OP_PUSH_BACK;
			else if (r < w_pb + w_pf) func = cedq_pkg::OP_PUSH_FRONT;
			else if (r < w_pb + w_pf + w_pop) func = cedq_pkg::OP_POP_BACK;
			else if (r < w_pb + w_pf + w_pop + w_rot) func = cedq_pkg::OP_ROTATE;
			else if (r < total - w_spare) func = cedq_pkg::OP_PEEK;
			else func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
			gap = steady ? 0 : pick_gap();
			send(func, rand_entry(), gap);
		end
		// hold off until every result of this phase is back
		drain();
	endtask

	// result side: random stalls, quiet stretches and one long hold
	initial begin
		int unsigned step;
		int unsigned busy_len;
		int unsigned stall_len;
		step = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			busy_len = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 80)
			                                        : $urandom_range(1, 6);
			repeat (busy_len) @(posedge clk);
			stall_len = (step == 30) ? LONG_HOLD : pick_gap();
			if (stall_len != 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
			step++;
		end
	end

	initial begin
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty deque corner cases
		send(cedq_pkg::OP_PEEK, fixed_entry('1, 8'hff), pick_gap());
		send(cedq_pkg::OP_POP_BACK, fixed_entry('1, 8'hff), pick_gap());
		send(cedq_pkg::OP_ROTATE, fixed_entry('1, 8'hff), pick_gap());
		send(cedq_pkg::OP_PUSH_BACK, fixed_entry('1, 8'hff), pick_gap());
		// rotate with a single entry does nothing
		send(cedq_pkg::OP_ROTATE, rand_entry(), pick_gap());
		send(cedq_pkg::OP_PUSH_FRONT, fixed_entry('0, 8'h00), pick_gap());
		send(cedq_pkg::OP_PEEK, rand_entry(), pick_gap());
		send(cedq_pkg::OP_ROTATE, rand_entry(), pick_gap());
		send(cedq_pkg::OP_PUSH_BACK, fixed_entry({16{4'h5}}, 8'haa), pick_gap());
		send(cedq_pkg::OP_PUSH_FRONT, fixed_entry({16{4'ha}}, 8'h55), pick_gap());
		send(cedq_pkg::OP_ROTATE, rand_entry(), pick_gap());
		send(cedq_pkg::OP_POP_BACK, rand_entry(), pick_gap());
		send(FUNC_SPARE_FIRST, rand_entry(), pick_gap());
		send(FUNC_SPARE_MID, rand_entry(), pick_gap());
		send(FUNC_SPARE_LAST, rand_entry(), pick_gap());
		send(cedq_pkg::OP_POP_BACK, rand_entry(), pick_gap());
		send(cedq_pkg::OP_POP_BACK, rand_entry(), pick_gap());
		send(cedq_pkg::OP_POP_BACK, rand_entry(), pick_gap());
		send(cedq_pkg::OP_POP_BACK, rand_entry(), pick_gap());
		drain();

		// mixed, fill to capacity, churn while full, drain, mixed again
		run_phase(60, 25, 25, 20, 20, 5, 5);
		run_phase(90, 45, 40, 3, 10, 1, 1);
		run_phase(40, 30, 30, 10, 28, 1, 1);
		run_phase(90, 5, 5, 70, 15, 3, 2);
		run_phase(120, 25, 25, 25, 20, 3, 2);

		repeat (TAIL_WAIT) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("PASS circular_edge_deque_with_rotate");
		end else begin
			$display("FAIL circular_edge_deque_with_rotate");
		end
		$finish;
	end

endmodule

`default_nettype wire
